/* hw/rtl/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
package dq_pkg;

  // Operation codes carried in the kind field of an operation transaction.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
  localparam logic [2:0] KIND_PEEK_BACK  = 3'd5;
  localparam logic [2:0] KIND_CLEAR      = 3'd6;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned FIELD_DW = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef struct packed {
    logic [2:0]          kind;
    logic [FIELD_DW-1:0] push_data;
  } op_t;

  typedef struct packed {
    logic [FIELD_DW-1:0] read_data;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } res_t;

  // Per-cycle command broadcast to every cell of the chain; at most one is set.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear_all;
  } cell_ctl_t;

endpackage

/* hw/rtl/dq_cell.sv */
// One storage cell of the deque chain, holding one entry and its occupied flag.
module dq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dq_pkg::cell_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_occ,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  occ,
  output logic [DATA_WIDTH-1:0] tail_data
);

  // Entries stay packed toward the front, so the back entry is the last occupied cell.
  logic is_tail;

  assign is_tail   = occ && !right_occ;
  assign tail_data = is_tail ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      priority if (ctl.clear_all) begin
        occ <= 1'b0;
      end else if (ctl.push_front) begin
        occ <= left_occ;
      end else if (ctl.pop_front) begin
        occ <= right_occ;
      end else if (ctl.push_back) begin
        if (!occ && left_occ) begin
          occ <= 1'b1;
        end
      end else if (ctl.pop_back) begin
        if (is_tail) begin
          occ <= 1'b0;
        end
      end else begin
        occ <= occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.push_front) begin
      data <= left_data;
    end else if (ctl.pop_front) begin
      data <= right_data;
    end else if (ctl.push_back && !occ && left_occ) begin
      data <= push_data;
    end else begin
      data <= data;
    end
  end

endmodule

/* hw/rtl/double_ended_queue.sv */
// Top level of the double-ended queue built from a chain of storage cells.
//
// The double-ended queue holds up to DEPTH entries of DATA_WIDTH bits in a row of
// identical cells, packed toward cell zero: cell zero is always the front entry and
// the last occupied cell is the back entry. A push at the front shifts every entry
// one cell toward the back, a pop at the front shifts every entry one cell toward
// the front, and pushes and pops at the back touch only the cell at the boundary of
// the occupied region, so every operation is made of neighbor-to-neighbor
// transfers. The block accepts one operation transaction per clock cycle and returns
// exactly one result transaction for it in the following cycle from an output
// register; a new operation is taken in the same cycle that the waiting result is
// taken, so throughput is one operation per cycle unless the result side stalls.
// The result carries the popped or peeked value (zero otherwise), the status (ok,
// empty for a pop or peek on an empty queue, full for a push into a full queue),
// the entry count after the operation and an empty flag. Refused operations and
// unknown kind codes leave the contents unchanged. Clear empties the queue.
// Push data wider than DATA_WIDTH is truncated; read data is zero-extended.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_stall,
  input  dq_pkg::op_t  op,
  output logic         res_valid,
  input  logic         res_stall,
  output dq_pkg::res_t res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // The number of live entries, kept alongside the cell flags for full and empty.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [DEPTH-1:0]                 occ;
  logic [DATA_WIDTH-1:0]            cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]            cell_tail [DEPTH];
  logic [DATA_WIDTH-1:0]            back_data;
  logic [DATA_WIDTH-1:0]            push_word;
  logic [63:0]                      push_wide;
  logic [63:0]                      read_wide;
  logic [DATA_WIDTH-1:0]            read_word;
  dq_pkg::cell_ctl_t                ctl;
  dq_pkg::res_t                     res_next;
  logic                             op_accept;
  logic                             full;
  logic                             empty;

  // The result register is the only buffer: an operation may enter whenever the
  // result register is free or is being emptied in this cycle.
  assign op_stall  = res_valid && res_stall;
  assign op_accept = op_valid && !op_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign push_wide = 64'(op.push_data);
  assign push_word = push_wide[DATA_WIDTH-1:0];

  // The back entry is found by an AND-OR select over the cells' tail outputs;
  // at most one cell marks itself as the tail.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  // Decode the transaction into one cell command, with refusals filtered out.
  always_comb begin
    ctl        = '0;
    count_next = count;
    read_word  = '0;
    res_next   = '0;
    res_next.status = dq_pkg::STATUS_OK;
    unique case (op.kind)
      dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          res_next.status = dq_pkg::STATUS_FULL;
        end else begin
          ctl.push_front = (op.kind == dq_pkg::KIND_PUSH_FRONT);
          ctl.push_back  = (op.kind == dq_pkg::KIND_PUSH_BACK);
          count_next     = CW'(count + 1'b1);
        end
      end
      dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_PEEK_FRONT: begin
        if (empty) begin
          res_next.status = dq_pkg::STATUS_EMPTY;
        end else begin
          read_word = cell_data[0];
          if (op.kind == dq_pkg::KIND_POP_FRONT) begin
            ctl.pop_front = 1'b1;
            count_next    = CW'(count - 1'b1);
          end
        end
      end
      dq_pkg::KIND_POP_BACK, dq_pkg::KIND_PEEK_BACK: begin
        if (empty) begin
          res_next.status = dq_pkg::STATUS_EMPTY;
        end else begin
          read_word = back_data;
          if (op.kind == dq_pkg::KIND_POP_BACK) begin
            ctl.pop_back = 1'b1;
            count_next   = CW'(count - 1'b1);
          end
        end
      end
      dq_pkg::KIND_CLEAR: begin
        ctl.clear_all = 1'b1;
        count_next    = '0;
      end
      default: begin
        // An unknown kind is answered with the current count and changes nothing.
      end
    endcase
    read_wide            = 64'(read_word);
    res_next.read_data   = read_wide[dq_pkg::FIELD_DW-1:0];
    res_next.entry_count = dq_pkg::COUNT_W'(count_next);
    res_next.is_empty    = (count_next == '0);
    if (!op_accept) begin
      ctl = '0;
    end
  end

  // The chain of cells; cell zero sees the push data as an always-occupied left
  // neighbor, and the last cell sees an empty right neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_occ;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_occ;

    if (g == 0) begin : g_first
      assign left_data = push_word;
      assign left_occ  = 1'b1;
    end else begin : g_inner_left
      assign left_data = cell_data[g-1];
      assign left_occ  = occ[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner_right
      assign right_data = cell_data[g+1];
      assign right_occ  = occ[g+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .push_data (push_word),
      .left_data (left_data),
      .left_occ  (left_occ),
      .right_data(right_data),
      .right_occ (right_occ),
      .data      (cell_data[g]),
      .occ       (occ[g]),
      .tail_data (cell_tail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (op_accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_accept) begin
      res <= res_next;
    end
  end

  // The count register must always agree with the occupied flags of the cells.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == count)
    else $error("entry count disagrees with occupied cells");

  // Occupied cells form one unbroken run starting at cell zero.
  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((occ + 1'b1) & occ) == '0)
    else $error("occupied cells are not packed toward the front");

  // A push refused as full leaves the queue full.
  a_full_refusal_holds: assert property (@(posedge clk) disable iff (rst)
    (op_accept && full &&
     (op.kind == dq_pkg::KIND_PUSH_FRONT || op.kind == dq_pkg::KIND_PUSH_BACK))
    |=> (count == CW'(DEPTH)) && (res.status == dq_pkg::STATUS_FULL))
    else $error("refused push changed the queue");

  // A result is never left waiting while a new transaction overwrites it.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid && $stable(res))
    else $error("stalled result was lost or changed");

endmodule
